// ===== hw/rtl/hxld_pkg.sv =====
// Shared types and character constants for the hex text memory loader.
package hxld_pkg;

  localparam int unsigned CFG_INDEX_W = 1;
  localparam int unsigned CFG_DATA_W  = 17;

  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_BASE = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_SIZE = 1'd1;

  localparam logic [15:0] WINDOW_BASE_RST = 16'd0;
  localparam logic [16:0] WINDOW_SIZE_RST = 17'd49152;

  localparam logic [7:0] CH_DOT     = 8'h2e;
  localparam logic [7:0] CH_EQUAL   = 8'h3d;
  localparam logic [7:0] CH_PERCENT = 8'h25;
  localparam logic [7:0] CH_S       = 8'h73;
  localparam logic [7:0] CH_G       = 8'h67;
  localparam logic [7:0] CH_COMMA   = 8'h2c;
  localparam logic [7:0] CH_BANG    = 8'h21;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_TAB     = 8'h09;
  localparam logic [7:0] CH_LF      = 8'h0a;
  localparam logic [7:0] CH_CR      = 8'h0d;
  localparam logic [7:0] CH_0       = 8'h30;
  localparam logic [7:0] CH_9       = 8'h39;
  localparam logic [7:0] CH_UA      = 8'h41;
  localparam logic [7:0] CH_UF      = 8'h46;
  localparam logic [7:0] CASE_MASK  = 8'hdf;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_ADDR  = 2'd1,
    KIND_BREAK = 2'd2
  } kind_t;

  typedef struct packed {
    logic       is_dot;
    logic       is_space;
    logic       is_hex;
    logic [3:0] digit;
    logic       is_bang;
    logic       is_s;
    logic       is_g;
    logic       is_comma;
    logic       is_equal;
    logic       is_percent;
  } char_class_t;

endpackage

// ===== hw/rtl/hex_text_memory_loader.sv =====
// Top level of the hex text memory loader: parse state and result register.
//
//  channel | direction | handshake            | payload
//  in      | input     | in_valid / in_ready  | in_rx_byte
//  out     | output    | out_valid / out_ready| write, clear, dump and status fields
//  cfg     | input     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One byte per cycle while the output is not stalled; each accepted byte
// yields one word in the result register in the next cycle. in_ready is high
// while the result register is empty or being taken, so a stalled output holds the input only.
// rst_n is synchronous; it clears the parse state and restores the window.
// cfg_ready is always high.
module hex_text_memory_loader #(
  parameter int unsigned ADDRESS_BITS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [7:0]                        in_rx_byte,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_write_valid,
  output logic [15:0]                       out_write_address,
  output logic [15:0]                       out_write_word,
  output logic                              out_clear_request,
  output logic                              out_dump_request,
  output logic                              out_finished,
  output logic                              out_step_mode,
  output logic [15:0]                       out_break_value,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [hxld_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [hxld_pkg::CFG_DATA_W-1:0]   cfg_data
);

  localparam int unsigned CW = (ADDRESS_BITS > 17) ? ADDRESS_BITS + 1 : 18;

  hxld_pkg::char_class_t cls;

  logic [1:0]              dot_run_r, dot_run_nxt;
  logic                    in_number_r, in_number_nxt;
  hxld_pkg::kind_t         kind_r, kind_nxt;
  logic [15:0]             acc_r, acc_nxt;
  logic [ADDRESS_BITS-1:0] load_addr_r, load_addr_nxt;
  logic [ADDRESS_BITS-1:0] break_r, break_nxt;
  logic                    any_written_r, any_written_nxt;
  logic                    done_r, done_nxt;
  logic                    step_r, step_nxt;
  logic [15:0]             window_base_r;
  logic [16:0]             window_size_r;

  logic                    out_valid_r;
  logic                    wr_valid_r, wr_valid_nxt;
  logic [15:0]             wr_addr_r, wr_addr_nxt;
  logic [15:0]             wr_word_r, wr_word_nxt;
  logic                    clear_r, clear_nxt;
  logic                    dump_r, dump_nxt;

  logic                    accept;
  logic                    end_num;
  hxld_pkg::kind_t         end_kind;
  logic [15:0]             end_acc;
  logic [CW-1:0]           addr_ext, base_ext, top_ext, acc_ext, break_ext;
  logic                    in_window;
  logic [1:0]              dot_inc;

  hxld_char_class u_class (
    .rx_byte (in_rx_byte),
    .cls     (cls)
  );

  assign accept    = in_valid && in_ready;
  assign in_ready  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  assign addr_ext  = {{(CW-ADDRESS_BITS){1'b0}}, load_addr_r};
  assign base_ext  = {{(CW-16){1'b0}}, window_base_r};
  assign top_ext   = base_ext + {{(CW-17){1'b0}}, window_size_r};
  assign in_window = (addr_ext >= base_ext) && (addr_ext < top_ext);
  assign dot_inc   = dot_run_r + 2'd1;

  always_comb begin
    dot_run_nxt     = dot_run_r;
    in_number_nxt   = in_number_r;
    kind_nxt        = kind_r;
    acc_nxt         = acc_r;
    load_addr_nxt   = load_addr_r;
    break_nxt       = break_r;
    any_written_nxt = any_written_r;
    done_nxt        = done_r;
    step_nxt        = step_r;
    wr_valid_nxt    = 1'b0;
    wr_addr_nxt     = 16'd0;
    wr_word_nxt     = 16'd0;
    clear_nxt       = 1'b0;
    dump_nxt        = 1'b0;
    end_num         = 1'b0;
    end_kind        = kind_r;
    end_acc         = acc_r;

    if (!done_r) begin
      if (cls.is_dot) begin
        dot_run_nxt = dot_inc;
        if (dot_inc == 2'd3) begin
          done_nxt      = 1'b1;
          in_number_nxt = 1'b0;
          dot_run_nxt   = 2'd0;
        end
      end else begin
        dot_run_nxt = 2'd0;
        if (in_number_r) begin
          if (cls.is_hex) begin
            acc_nxt = {acc_r[11:0], cls.digit};
          end else begin
            end_num = 1'b1;
          end
        end else if (cls.is_space) begin
          dot_run_nxt = 2'd0;
        end else if (cls.is_bang && any_written_r) begin
          dump_nxt = 1'b1;
        end else if (cls.is_s) begin
          step_nxt = 1'b1;
          done_nxt = 1'b1;
        end else if (cls.is_g) begin
          step_nxt = 1'b0;
          done_nxt = 1'b1;
        end else if (cls.is_comma) begin
          clear_nxt = 1'b1;
        end else if (cls.is_equal || cls.is_percent) begin
          in_number_nxt = 1'b1;
          kind_nxt      = cls.is_equal ? hxld_pkg::KIND_ADDR : hxld_pkg::KIND_BREAK;
          acc_nxt       = 16'd0;
        end else begin
          kind_nxt = hxld_pkg::KIND_DATA;
          if (cls.is_hex) begin
            in_number_nxt = 1'b1;
            acc_nxt       = {12'd0, cls.digit};
          end else begin
            acc_nxt  = 16'd0;
            end_num  = 1'b1;
            end_kind = hxld_pkg::KIND_DATA;
            end_acc  = 16'd0;
          end
        end
      end
    end

    acc_ext = {{(CW-16){1'b0}}, end_acc};

    if (end_num) begin
      in_number_nxt = 1'b0;
      case (end_kind)
        hxld_pkg::KIND_ADDR: begin
          load_addr_nxt = acc_ext[ADDRESS_BITS-1:0];
        end
        hxld_pkg::KIND_BREAK: begin
          break_nxt = acc_ext[ADDRESS_BITS-1:0];
        end
        default: begin
          if (in_window) begin
            wr_valid_nxt    = 1'b1;
            wr_addr_nxt     = addr_ext[15:0];
            wr_word_nxt     = end_acc;
            load_addr_nxt   = load_addr_r + ADDRESS_BITS'(2);
            any_written_nxt = 1'b1;
          end
        end
      endcase
    end

    break_ext = {{(CW-ADDRESS_BITS){1'b0}}, break_nxt};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dot_run_r     <= 2'd0;
      in_number_r   <= 1'b0;
      kind_r        <= hxld_pkg::KIND_DATA;
      acc_r         <= 16'd0;
      load_addr_r   <= '0;
      break_r       <= '0;
      any_written_r <= 1'b0;
      done_r        <= 1'b0;
      step_r        <= 1'b0;
    end else if (accept) begin
      dot_run_r     <= dot_run_nxt;
      in_number_r   <= in_number_nxt;
      kind_r        <= kind_nxt;
      acc_r         <= acc_nxt;
      load_addr_r   <= load_addr_nxt;
      break_r       <= break_nxt;
      any_written_r <= any_written_nxt;
      done_r        <= done_nxt;
      step_r        <= step_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_base_r <= hxld_pkg::WINDOW_BASE_RST;
      window_size_r <= hxld_pkg::WINDOW_SIZE_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        hxld_pkg::CFG_WINDOW_BASE: window_base_r <= cfg_data[15:0];
        hxld_pkg::CFG_WINDOW_SIZE: window_size_r <= cfg_data[16:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      wr_valid_r      <= wr_valid_nxt;
      wr_addr_r       <= wr_addr_nxt;
      wr_word_r       <= wr_word_nxt;
      clear_r         <= clear_nxt;
      dump_r          <= dump_nxt;
      out_finished    <= done_nxt;
      out_step_mode   <= step_nxt;
      out_break_value <= break_ext[15:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_write_valid   = wr_valid_r;
  assign out_write_address = wr_addr_r;
  assign out_write_word    = wr_word_r;
  assign out_clear_request = clear_r;
  assign out_dump_request  = dump_r;

  // a write never lands on the word that ends the load
  a_write_not_finished: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && wr_valid_r |-> !out_finished)
    else $error("write issued on a finishing word");

  a_done_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> done_r)
    else $error("load end flag dropped");

  a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !wr_valid_r |-> (wr_addr_r == 16'd0) && (wr_word_r == 16'd0))
    else $error("write fields not zero without a write");

  a_no_work_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    accept && done_r |=> !wr_valid_r && !clear_r && !dump_r)
    else $error("request issued after load ended");

endmodule

// ===== hw/rtl/hxld_char_class.sv =====
// Character classifier: hex digit value and command character flags.
module hxld_char_class (
  input  logic [7:0]                rx_byte,
  output hxld_pkg::char_class_t     cls
);

  logic [7:0] upper;
  logic       is_dec;
  logic       is_alpha_hex;

  assign upper        = rx_byte & hxld_pkg::CASE_MASK;
  assign is_dec       = (rx_byte >= hxld_pkg::CH_0) && (rx_byte <= hxld_pkg::CH_9);
  assign is_alpha_hex = (upper >= hxld_pkg::CH_UA) && (upper <= hxld_pkg::CH_UF);

  always_comb begin
    cls            = '0;
    cls.is_dot     = (rx_byte == hxld_pkg::CH_DOT);
    cls.is_space   = (rx_byte == hxld_pkg::CH_SPACE) || (rx_byte == hxld_pkg::CH_TAB) ||
                     (rx_byte == hxld_pkg::CH_LF) || (rx_byte == hxld_pkg::CH_CR);
    cls.is_hex     = is_dec || is_alpha_hex;
    cls.is_bang    = (rx_byte == hxld_pkg::CH_BANG);
    cls.is_s       = (rx_byte == hxld_pkg::CH_S);
    cls.is_g       = (rx_byte == hxld_pkg::CH_G);
    cls.is_comma   = (rx_byte == hxld_pkg::CH_COMMA);
    cls.is_equal   = (rx_byte == hxld_pkg::CH_EQUAL);
    cls.is_percent = (rx_byte == hxld_pkg::CH_PERCENT);
    if (is_dec) begin
      cls.digit = rx_byte[3:0];
    end else if (is_alpha_hex) begin
      cls.digit = 4'(upper - hxld_pkg::CH_UA + 8'd10);
    end else begin
      cls.digit = 4'd0;
    end
  end

endmodule

// ===== tb/hex_text_memory_loader_test.sv =====
// Self-checking testbench for hex_text_memory_loader: byte stream in, predicted status words out.
`timescale 1ns / 1ps

module hex_text_memory_loader_test;

  localparam int IDLE_LIMIT = 2000;
  localparam int MAX_REPORTS = 100;

  typedef struct packed {
    logic        wr;
    logic [15:0] addr;
    logic [15:0] word;
    logic        clr;
    logic        dump;
    logic        fin;
    logic        step;
    logic [15:0] brk;
  } load_word_t;

  logic                             clk = 1'b0;
  logic                             rst_n;
  logic                             in_valid;
  logic                             in_ready;
  logic [7:0]                       in_rx_byte;
  logic                             out_valid;
  logic                             out_ready;
  logic                             out_write_valid;
  logic [15:0]                      out_write_address;
  logic [15:0]                      out_write_word;
  logic                             out_clear_request;
  logic                             out_dump_request;
  logic                             out_finished;
  logic                             out_step_mode;
  logic [15:0]                      out_break_value;
  logic                             cfg_valid;
  logic                             cfg_ready;
  logic [hxld_pkg::CFG_INDEX_W-1:0] cfg_index;
  logic [hxld_pkg::CFG_DATA_W-1:0]  cfg_data;

  // parser copy
  logic [1:0]      p_dots;
  logic            p_in_num;
  hxld_pkg::kind_t p_kind;
  logic [15:0]     p_acc;
  logic [15:0]     p_addr;
  logic [15:0]     p_brk;
  logic            p_any;
  logic            p_done;
  logic            p_step;
  logic [15:0]     p_base;
  logic [16:0]     p_size;

  load_word_t due_words[$];
  int         fail_count = 0;
  int         idle_cycles = 0;
  int         gap_pct = 0;
  int         stall_pct = 0;
  int         stall_left = 0;
  int         bytes_sent = 0;

  hex_text_memory_loader u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_rx_byte        (in_rx_byte),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_write_valid   (out_write_valid),
    .out_write_address (out_write_address),
    .out_write_word    (out_write_word),
    .out_clear_request (out_clear_request),
    .out_dump_request  (out_dump_request),
    .out_finished      (out_finished),
    .out_step_mode     (out_step_mode),
    .out_break_value   (out_break_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  always #5 clk = ~clk;

  function automatic int pick_gap(int pct);
    if ($urandom_range(0, 99) >= pct) return 0;
    if ($urandom_range(0, 9) == 0) return $urandom_range(10, 40);
    return $urandom_range(1, 3);
  endfunction

  function automatic logic [4:0] hex_value(logic [7:0] b);
    logic [7:0] u;
    u = b & hxld_pkg::CASE_MASK;
    if (b >= hxld_pkg::CH_0 && b <= hxld_pkg::CH_9) return {1'b1, 4'(b - hxld_pkg::CH_0)};
    if (u >= hxld_pkg::CH_UA && u <= hxld_pkg::CH_UF)
      return {1'b1, 4'(u - hxld_pkg::CH_UA + 8'd10)};
    return 5'd0;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    logic [7:0] c;
    if (n < 4'd10) c = hxld_pkg::CH_0 + 8'(n);
    else c = hxld_pkg::CH_UA + 8'(n) - 8'd10;
    if ($urandom_range(0, 1) == 1) c = c | ~hxld_pkg::CASE_MASK;
    return c;
  endfunction

  function automatic logic [7:0] blank_char();
    case ($urandom_range(0, 3))
      0: return hxld_pkg::CH_SPACE;
      1: return hxld_pkg::CH_TAB;
      2: return hxld_pkg::CH_LF;
      default: return hxld_pkg::CH_CR;
    endcase
  endfunction

  function automatic logic [7:0] number_end();
    logic [7:0] b;
    logic [4:0] hv;
    if ($urandom_range(0, 4) != 0) return blank_char();
    do begin
      b = 8'($urandom);
      hv = hex_value(b);
    end while (hv[4] || b == hxld_pkg::CH_DOT);
    return b;
  endfunction

  // keeps random text from ending the load early
  function automatic logic [7:0] keep_loading(logic [7:0] b);
    if ((!p_in_num && (b == hxld_pkg::CH_S || b == hxld_pkg::CH_G)) ||
        (b == hxld_pkg::CH_DOT && p_dots == 2'd2))
      return b ^ 8'h80;
    return b;
  endfunction

  task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
    if (fail_count < MAX_REPORTS)
      $display("mismatch on %s: got %h, want %h at %0t", what, got, want, $realtime);
    fail_count++;
  endtask

  task automatic check_field(string what, logic [15:0] got, logic [15:0] want);
    if (got !== want) report_mismatch(what, got, want);
  endtask

  task automatic close_number(inout load_word_t r);
    logic [17:0] top;
    p_in_num = 1'b0;
    if (p_kind == hxld_pkg::KIND_ADDR) begin
      p_addr = p_acc;
    end else if (p_kind == hxld_pkg::KIND_BREAK) begin
      p_brk = p_acc;
    end else begin
      top = {2'b00, p_base} + {1'b0, p_size};
      if ({2'b00, p_addr} >= {2'b00, p_base} && {2'b00, p_addr} < top) begin
        r.wr = 1'b1;
        r.addr = p_addr;
        r.word = p_acc;
        p_addr = p_addr + 16'd2;
        p_any = 1'b1;
      end
    end
  endtask

  task automatic parse_text_byte(logic [7:0] b);
    load_word_t r;
    logic [4:0] hv;
    r = '0;
    if (!p_done) begin
      if (b == hxld_pkg::CH_DOT) begin
        p_dots = p_dots + 2'd1;
        if (p_dots == 2'd3) begin
          p_done = 1'b1;
          p_in_num = 1'b0;
          p_dots = 2'd0;
        end
      end else begin
        p_dots = 2'd0;
        hv = hex_value(b);
        if (p_in_num) begin
          if (hv[4]) p_acc = {p_acc[11:0], hv[3:0]};
          else close_number(r);
        end else if (b == hxld_pkg::CH_SPACE || b == hxld_pkg::CH_TAB ||
                     b == hxld_pkg::CH_LF || b == hxld_pkg::CH_CR) begin
        end else if (b == hxld_pkg::CH_BANG && p_any) begin
          r.dump = 1'b1;
        end else if (b == hxld_pkg::CH_S) begin
          p_step = 1'b1;
          p_done = 1'b1;
        end else if (b == hxld_pkg::CH_G) begin
          p_step = 1'b0;
          p_done = 1'b1;
        end else if (b == hxld_pkg::CH_COMMA) begin
          r.clr = 1'b1;
        end else if (b == hxld_pkg::CH_EQUAL || b == hxld_pkg::CH_PERCENT) begin
          p_in_num = 1'b1;
          p_kind = (b == hxld_pkg::CH_EQUAL) ? hxld_pkg::KIND_ADDR : hxld_pkg::KIND_BREAK;
          p_acc = 16'd0;
        end else begin
          p_kind = hxld_pkg::KIND_DATA;
          p_acc = 16'd0;
          if (hv[4]) begin
            p_in_num = 1'b1;
            p_acc = {12'd0, hv[3:0]};
          end else begin
            close_number(r);
          end
        end
      end
    end
    r.fin = p_done;
    r.step = p_step;
    r.brk = p_brk;
    due_words.push_back(r);
  endtask

  task automatic send_byte(logic [7:0] b);
    int gap;
    gap = pick_gap(gap_pct);
    @(negedge clk);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_rx_byte <= b;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    parse_text_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text_byte(logic [7:0] b);
    send_byte(keep_loading(b));
  endtask

  task automatic send_number(bit has_lead, logic [7:0] lead, logic [23:0] digits, int count);
    if (has_lead) send_text_byte(lead);
    for (int k = count - 1; k >= 0; k--) begin
      send_text_byte(hex_char(digits[4*k +: 4]));
      if ($urandom_range(0, 9) == 0) send_text_byte(hxld_pkg::CH_DOT);
    end
    send_text_byte(number_end());
  endtask

  task automatic send_random_record();
    int pick;
    int span;
    logic [23:0] digits;
    pick = $urandom_range(0, 99);
    digits = 24'($urandom);
    if (pick < 45) begin
      send_number(1'b0, hxld_pkg::CH_0, digits, $urandom_range(1, 6));
    end else if (pick < 55) begin
      if (p_size != 0 && $urandom_range(0, 4) != 0) begin
        span = int'(p_size) - 1;
        if (int'(p_base) + span > 65535) span = 65535 - int'(p_base);
        digits[15:0] = p_base + 16'($urandom_range(0, span));
      end
      send_number(1'b1, hxld_pkg::CH_EQUAL, digits,
                  ($urandom_range(0, 3) == 0) ? $urandom_range(0, 3) : $urandom_range(4, 6));
    end else if (pick < 62) begin
      send_number(1'b1, hxld_pkg::CH_PERCENT, digits, $urandom_range(0, 6));
    end else if (pick < 68) begin
      send_text_byte(hxld_pkg::CH_COMMA);
    end else if (pick < 74) begin
      send_text_byte(hxld_pkg::CH_BANG);
    end else if (pick < 82) begin
      repeat ($urandom_range(1, 2)) send_text_byte(hxld_pkg::CH_DOT);
    end else if (pick < 90) begin
      repeat ($urandom_range(1, 4)) send_text_byte(blank_char());
    end else begin
      send_text_byte(8'($urandom));
    end
  endtask

  task automatic send_random_text(int count);
    int stop_at;
    stop_at = bytes_sent + count;
    while (bytes_sent < stop_at) send_random_record();
  endtask

  // sender holds off until every due word is back
  task automatic drain_results();
    @(negedge clk);
    in_valid <= 1'b0;
    while (due_words.size() != 0) @(posedge clk);
    repeat (2) @(posedge clk);
  endtask

  task automatic write_window_reg(logic [hxld_pkg::CFG_INDEX_W-1:0] idx, logic [16:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == hxld_pkg::CFG_WINDOW_BASE) p_base = val[15:0];
    else p_size = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_window(logic [15:0] base, logic [16:0] size);
    write_window_reg(hxld_pkg::CFG_WINDOW_BASE, {1'b0, base});
    write_window_reg(hxld_pkg::CFG_WINDOW_SIZE, size);
  endtask

  task automatic test_directed_text();
    logic [7:0] text[$];
    text = '{hxld_pkg::CH_BANG, hxld_pkg::CH_BANG, hxld_pkg::CH_COMMA,
             hxld_pkg::CH_SPACE, hxld_pkg::CH_TAB, hxld_pkg::CH_CR, hxld_pkg::CH_LF,
             hxld_pkg::CH_UA | ~hxld_pkg::CASE_MASK, hxld_pkg::CH_DOT, hxld_pkg::CH_UF,
             hxld_pkg::CH_SPACE,
             8'hff, 8'h00,
             hxld_pkg::CH_PERCENT, hxld_pkg::CH_UF | ~hxld_pkg::CASE_MASK, hxld_pkg::CH_UF,
             hxld_pkg::CH_0, hxld_pkg::CH_0 + 8'd1, hxld_pkg::CH_0 + 8'd5, hxld_pkg::CH_S,
             hxld_pkg::CH_EQUAL, hxld_pkg::CH_UF | ~hxld_pkg::CASE_MASK,
             hxld_pkg::CH_UF | ~hxld_pkg::CASE_MASK, hxld_pkg::CH_UF | ~hxld_pkg::CASE_MASK,
             (hxld_pkg::CH_UA + 8'd4) | ~hxld_pkg::CASE_MASK, hxld_pkg::CH_LF,
             hxld_pkg::CH_9, hxld_pkg::CH_SPACE};
    gap_pct = 20;
    stall_pct = 20;
    foreach (text[k]) send_byte(text[k]);
    drain_results();
  endtask

  task automatic test_address_wrap();
    logic [7:0] text[$];
    text = '{hxld_pkg::CH_EQUAL, hxld_pkg::CH_UF, hxld_pkg::CH_UF | ~hxld_pkg::CASE_MASK,
             hxld_pkg::CH_UF, hxld_pkg::CH_UA + 8'd4, hxld_pkg::CH_SPACE,
             hxld_pkg::CH_0 + 8'd1, hxld_pkg::CH_0 + 8'd2, hxld_pkg::CH_0 + 8'd3,
             hxld_pkg::CH_0 + 8'd4, hxld_pkg::CH_TAB,
             hxld_pkg::CH_UA + 8'd1, hxld_pkg::CH_UA + 8'd4, hxld_pkg::CH_UA + 8'd4,
             hxld_pkg::CH_UF, hxld_pkg::CH_CR, hxld_pkg::CH_BANG};
    set_window(16'h0000, 17'd65536);
    gap_pct = 0;
    stall_pct = 0;
    foreach (text[k]) send_byte(text[k]);
    drain_results();
  endtask

  task automatic test_window_sweep();
    logic [15:0] base;
    logic [16:0] size;
    for (int i = 0; i < 8; i++) begin
      case (i)
        0: begin base = 16'h0000; size = 17'd65536; end
        1: begin base = 16'h0000; size = 17'd0; end
        2: begin base = 16'hffff; size = 17'd1; end
        3: begin base = 16'hffff; size = 17'd65536; end
        4: begin base = 16'h8000; size = 17'd256; end
        7: begin base = hxld_pkg::WINDOW_BASE_RST; size = hxld_pkg::WINDOW_SIZE_RST; end
        default: begin
          base = 16'($urandom);
          size = 17'($urandom_range(0, 65536));
        end
      endcase
      set_window(base, size);
      gap_pct = (i % 4) * 25;
      stall_pct = ((i + 2) % 4) * 25;
      send_random_text(75);
      drain_results();
    end
  endtask

  task automatic test_load_end();
    gap_pct = 30;
    stall_pct = 30;
    case ($urandom_range(0, 2))
      0: begin
        send_byte(hxld_pkg::CH_SPACE);
        send_byte(hxld_pkg::CH_S);
      end
      1: begin
        send_byte(hxld_pkg::CH_SPACE);
        send_byte(hxld_pkg::CH_G);
      end
      default: begin
        send_byte(hxld_pkg::CH_0 + 8'd7);
        repeat (3) send_byte(hxld_pkg::CH_DOT);
      end
    endcase
    send_byte(hxld_pkg::CH_EQUAL);
    send_byte(hxld_pkg::CH_COMMA);
    send_byte(hxld_pkg::CH_BANG);
    repeat (20) send_byte(8'($urandom));
    drain_results();
  endtask

  always @(negedge clk) begin
    if (stall_left != 0) begin
      out_ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      out_ready <= 1'b1;
      stall_left <= pick_gap(stall_pct);
    end
  end

  always @(posedge clk) begin : check_words
    load_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (due_words.size() == 0) begin
        report_mismatch("word with nothing due", 16'd0, 16'd0);
      end else begin
        want = due_words.pop_front();
        check_field("write_valid", 16'(out_write_valid), 16'(want.wr));
        check_field("write_address", out_write_address, want.addr);
        check_field("write_word", out_write_word, want.word);
        check_field("clear_request", 16'(out_clear_request), 16'(want.clr));
        check_field("dump_request", 16'(out_dump_request), 16'(want.dump));
        check_field("finished", 16'(out_finished), 16'(want.fin));
        check_field("step_mode", 16'(out_step_mode), 16'(want.step));
        check_field("break_value", out_break_value, want.brk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_rx_byte = 8'd0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = hxld_pkg::CFG_WINDOW_BASE;
    cfg_data = '0;
    p_dots = 2'd0;
    p_in_num = 1'b0;
    p_kind = hxld_pkg::KIND_DATA;
    p_acc = 16'd0;
    p_addr = 16'd0;
    p_brk = 16'd0;
    p_any = 1'b0;
    p_done = 1'b0;
    p_step = 1'b0;
    p_base = hxld_pkg::WINDOW_BASE_RST;
    p_size = hxld_pkg::WINDOW_SIZE_RST;
    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    test_directed_text();
    test_address_wrap();
    test_window_sweep();
    test_load_end();
    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
